// ===== sv/length_prefixed_string_decoder_top_macros.svh =====
// ---------------------------------------------------------------------------
// length_prefixed_string_decoder_top_macros.svh
// assertion macros used by the decoder top
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_STRING_DECODER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_STRING_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define LPSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LPSD_ASSERT_NOW(lbl, ante, cons, msg)
`define LPSD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/lpsd_pkg.sv =====
// ---------------------------------------------------------------------------
// lpsd_pkg
// shared types and constants of the length-prefixed string decoder
// ---------------------------------------------------------------------------
package lpsd_pkg;

	// width of header values and of the payload byte count
	localparam int LEN_BITS = 16;
	// accumulator times ten plus a digit fits in four more bits
	localparam int PROD_BITS = LEN_BITS + 4;

	localparam logic [7:0] DELIM   = 8'h3B;
	localparam logic [7:0] DIGIT_0 = 8'h30;
	localparam logic [7:0] DIGIT_9 = 8'h39;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	// one result of the decoder core
	typedef struct packed {
		logic        emit;
		kind_t       kind;
		logic [7:0]  byte_out;
		logic        string_end;
		logic        message_end;
	} lpsd_res_t;

endpackage

// ===== sv/lpsd_in_if.sv =====
// ---------------------------------------------------------------------------
// lpsd_in_if
// byte channel into the decoder
// ---------------------------------------------------------------------------
interface lpsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	logic       last;

	modport source (output valid, output data, output last, input ready);
	modport sink (input valid, input data, input last, output ready);
endinterface

// ===== sv/lpsd_out_if.sv =====
// ---------------------------------------------------------------------------
// lpsd_out_if
// result channel out of the decoder
// ---------------------------------------------------------------------------
interface lpsd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] byte_out;
	logic       string_end;
	logic       message_end;

	modport source (output valid, output kind, output byte_out, output string_end,
		output message_end, input ready);
	modport sink (input valid, input kind, input byte_out, input string_end,
		input message_end, output ready);
endinterface

// ===== sv/lpsd_core.sv =====
// ---------------------------------------------------------------------------
// lpsd_core
// deframing state and per-byte decode, one byte per step
// ---------------------------------------------------------------------------
module lpsd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data,
	input  logic                  last,
	output lpsd_pkg::lpsd_res_t   res
);

	typedef enum logic [1:0] {
		PH_COUNT = 2'd0,
		PH_LEN   = 2'd1,
		PH_BODY  = 2'd2,
		PH_SKIP  = 2'd3
	} phase_t;

	phase_t                         phase_q, phase_d;
	logic [lpsd_pkg::LEN_BITS-1:0]  acc_q, acc_d;
	logic                           digit_seen_q, digit_seen_d;
	logic                           ignore_rest_q, ignore_rest_d;
	logic [lpsd_pkg::LEN_BITS-1:0]  bytes_left_q, bytes_left_d;

	logic [lpsd_pkg::PROD_BITS-1:0] prod;
	logic [lpsd_pkg::LEN_BITS-1:0]  left_dec;
	logic                           is_digit;
	logic                           do_fail;

	// acc * 10 + digit as two shifts and an add
	assign prod = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
		+ lpsd_pkg::PROD_BITS'(data - lpsd_pkg::DIGIT_0);
	assign left_dec = bytes_left_q - lpsd_pkg::LEN_BITS'(1);
	assign is_digit = (data >= lpsd_pkg::DIGIT_0) && (data <= lpsd_pkg::DIGIT_9);

	always_comb begin
		phase_d       = phase_q;
		acc_d         = acc_q;
		digit_seen_d  = digit_seen_q;
		ignore_rest_d = ignore_rest_q;
		bytes_left_d  = bytes_left_q;
		do_fail       = 1'b0;
		res           = '0;
		res.kind      = lpsd_pkg::KIND_BYTE;

		unique case (phase_q)
			PH_SKIP: begin
			end
			PH_BODY: begin
				bytes_left_d = left_dec;
				if (left_dec == '0) begin
					phase_d         = PH_LEN;
					res.emit        = 1'b1;
					res.byte_out    = data;
					res.string_end  = 1'b1;
					res.message_end = last;
				end else if (last) begin
					do_fail = 1'b1;
				end else begin
					res.emit     = 1'b1;
					res.byte_out = data;
				end
			end
			default: begin
				// count or length header
				if (data == lpsd_pkg::DELIM) begin
					if (!digit_seen_q) begin
						do_fail = 1'b1;
					end else begin
						acc_d         = '0;
						digit_seen_d  = 1'b0;
						ignore_rest_d = 1'b0;
						if (phase_q == PH_COUNT) begin
							phase_d = PH_LEN;
							if (last) begin
								res.emit        = 1'b1;
								res.kind        = lpsd_pkg::KIND_END;
								res.message_end = 1'b1;
							end
						end else if (acc_q == '0) begin
							res.emit        = 1'b1;
							res.kind        = lpsd_pkg::KIND_EMPTY;
							res.string_end  = 1'b1;
							res.message_end = last;
						end else if (last) begin
							do_fail = 1'b1;
						end else begin
							bytes_left_d = acc_q;
							phase_d      = PH_BODY;
						end
					end
				end else begin
					if (!ignore_rest_q) begin
						if (is_digit) begin
							if (prod[lpsd_pkg::PROD_BITS-1:lpsd_pkg::LEN_BITS] != '0) begin
								do_fail = 1'b1;
							end else begin
								acc_d        = prod[lpsd_pkg::LEN_BITS-1:0];
								digit_seen_d = 1'b1;
							end
						end else if (!digit_seen_q) begin
							do_fail = 1'b1;
						end else begin
							ignore_rest_d = 1'b1;
						end
					end
					// message ended inside a header field
					if (last) begin
						do_fail = 1'b1;
					end
				end
			end
		endcase

		if (do_fail) begin
			phase_d         = PH_SKIP;
			acc_d           = '0;
			digit_seen_d    = 1'b0;
			ignore_rest_d   = 1'b0;
			bytes_left_d    = '0;
			res             = '0;
			res.emit        = 1'b1;
			res.kind        = lpsd_pkg::KIND_ERROR;
			res.message_end = 1'b1;
		end

		// every message end returns to the reset state
		if (last) begin
			phase_d       = PH_COUNT;
			acc_d         = '0;
			digit_seen_d  = 1'b0;
			ignore_rest_d = 1'b0;
			bytes_left_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_COUNT;
			acc_q         <= '0;
			digit_seen_q  <= 1'b0;
			ignore_rest_q <= 1'b0;
			bytes_left_q  <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			acc_q         <= acc_d;
			digit_seen_q  <= digit_seen_d;
			ignore_rest_q <= ignore_rest_d;
			bytes_left_q  <= bytes_left_d;
		end
	end

endmodule

// ===== sv/length_prefixed_string_decoder_top.sv =====
// ---------------------------------------------------------------------------
// length_prefixed_string_decoder_top
// deframes, while not stalled, a decimal-count, length-prefixed string message one byte a cycle
// ---------------------------------------------------------------------------
// Takes one byte request per clock while not stalled and gives at most one
// result per byte: a payload byte (string_end on the last byte of each
// string), an empty-string marker, a clean end for a message holding only the
// count field, or a single error after which the rest of the message is
// dropped silently. Throughput is one byte per cycle while results are taken.
// An accepted byte sits in the input register, is decoded from it and has
// its result registered in the result register. A result that is not taken
// holds the byte in the input register, and intake stops only while that
// register is full. The state returns to reset after every byte marked last,
// so messages need no separator.
module length_prefixed_string_decoder_top (
	input  logic  clk,
	input  logic  arst_n,
	lpsd_in_if.sink     bytes,
	lpsd_out_if.source  results
);

`include "length_prefixed_string_decoder_top_macros.svh"

	// input register
	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 last_s1;

	// result register
	logic                 res_valid_q;
	lpsd_pkg::lpsd_res_t  res_q;

	lpsd_pkg::lpsd_res_t  core_res;
	logic                 advance;
	logic                 step;

	// the result register can take a new value when empty or being drained
	assign advance = !res_valid_q || results.ready;
	assign step    = valid_s1 && advance;
	assign bytes.ready = !valid_s1 || advance;

	lpsd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.data   (data_s1),
		.last   (last_s1),
		.res    (core_res)
	);

	// control flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (bytes.ready) begin
				valid_s1 <= bytes.valid;
			end
			if (advance) begin
				// bytes that produce nothing leave the result register empty
				res_valid_q <= step && core_res.emit;
			end
		end
	end

	// payload flops
	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			data_s1 <= bytes.data;
			last_s1 <= bytes.last;
		end
		if (step) begin
			res_q <= core_res;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.kind        = res_q.kind;
	assign results.byte_out    = res_q.byte_out;
	assign results.string_end  = res_q.string_end;
	assign results.message_end = res_q.message_end;

	// a stalled byte in the input register is neither lost nor changed
	`LPSD_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(data_s1) && $stable(last_s1), "input register lost a stalled byte")

	// only payload results carry a nonzero byte
	`LPSD_ASSERT_NOW(a_byte_zero, res_valid_q && res_q.kind != lpsd_pkg::KIND_BYTE, res_q.byte_out == 8'd0, "nonzero byte on a non-payload result")

	// error and clean end always close the message
	`LPSD_ASSERT_NOW(a_end_flag, res_valid_q && (res_q.kind == lpsd_pkg::KIND_ERROR || res_q.kind == lpsd_pkg::KIND_END), res_q.message_end && !res_q.string_end, "error or clean end without message end")

	// an empty string is always a string end
	`LPSD_ASSERT_NOW(a_empty_end, res_valid_q && res_q.kind == lpsd_pkg::KIND_EMPTY, res_q.string_end, "empty string result without string end")

endmodule
